// File: rtl/fa_pkg.sv
// shared types, codes and constants of the frame accumulator
`timescale 1ns / 1ps
package fa_pkg;

  localparam int unsigned FA_MAX_PIXELS = 65536;
  localparam int unsigned FA_CH_W       = 8;
  localparam int unsigned FA_WEIGHT_W   = 10;
  localparam int unsigned FA_FRAME_W    = 17;
  localparam int unsigned FA_CFG_IDX_W  = 2;
  localparam int unsigned FA_CFG_DATA_W = 17;
  localparam int unsigned FA_WEIGHT_MAX = 512;
  localparam int unsigned FA_FRAME_RST  = 65536;
  localparam int unsigned FA_WEIGHT_RST = 128;

  typedef enum logic [1:0] {
    FA_M_AVERAGE  = 2'd0,
    FA_M_SQUARE   = 2'd1,
    FA_M_PRODUCT  = 2'd2,
    FA_M_WEIGHTED = 2'd3
  } fa_method_e;

  typedef enum logic [FA_CFG_IDX_W-1:0] {
    FA_CFG_METHOD = 2'd0,
    FA_CFG_WEIGHT = 2'd1,
    FA_CFG_FRAME  = 2'd2
  } fa_cfg_idx_e;

  typedef struct packed {
    logic [FA_CH_W-1:0] in_ch0;
    logic [FA_CH_W-1:0] in_ch1;
    logic [FA_CH_W-1:0] in_ch2;
  } fa_pix_in_t;

  typedef struct packed {
    logic [FA_CH_W-1:0] out_ch0;
    logic [FA_CH_W-1:0] out_ch1;
    logic [FA_CH_W-1:0] out_ch2;
    logic               frame_last;
  } fa_pix_out_t;

  typedef struct packed {
    logic [FA_CFG_IDX_W-1:0]  reg_idx;
    logic [FA_CFG_DATA_W-1:0] wdata;
  } fa_cfg_t;

  typedef struct packed {
    fa_method_e             method;
    logic [FA_WEIGHT_W-1:0] weight;
  } fa_lane_cfg_t;

endpackage

// File: rtl/fa_chan_if.sv
// valid/ready channel carrying one word of a given payload type
`timescale 1ns / 1ps
interface fa_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/fa_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module fa_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/fa_lane.sv
// one color channel: combines stored and incoming value, rounds and saturates
`timescale 1ns / 1ps
module fa_lane (
  input  fa_pkg::fa_lane_cfg_t         cfg_i,
  input  logic [fa_pkg::FA_CH_W-1:0]   acc_i,
  input  logic [fa_pkg::FA_CH_W-1:0]   pix_i,
  output logic [fa_pkg::FA_CH_W-1:0]   res_o
);

  logic [8:0]         avg_sum;
  logic [8:0]         avg_res;
  logic [15:0]        sq_prod;
  logic [16:0]        sq_sum;
  logic signed [8:0]  wt_diff;
  logic signed [19:0] wt_prod;
  logic signed [20:0] wt_val;
  logic [12:0]        wt_quo;
  logic [7:0]         wt_rem;
  logic               wt_inc;
  logic [12:0]        wt_rnd;
  logic [7:0]         avg_out;
  logic [7:0]         sq_out;
  logic [7:0]         wt_out;

  always_comb begin
    // half of the sum, ties to even
    avg_sum = {1'b0, acc_i} + {1'b0, pix_i};
    avg_res = {1'b0, avg_sum[8:1]} + {8'd0, avg_sum[0] & avg_sum[1]};
    avg_out = (avg_res > 9'd255) ? 8'd255 : avg_res[7:0];

    sq_prod = {8'd0, pix_i} * {8'd0, pix_i};
    sq_sum  = {9'd0, acc_i} + {1'b0, sq_prod};
    sq_out  = (sq_sum > 17'd255) ? 8'd255 : sq_sum[7:0];

    // acc*256 + w*(in-acc) in signed q.8
    wt_diff = $signed({1'b0, pix_i}) - $signed({1'b0, acc_i});
    wt_prod = 20'($signed({1'b0, cfg_i.weight})) * 20'(wt_diff);
    wt_val  = $signed({5'd0, acc_i, 8'd0}) + 21'(wt_prod);
    wt_quo  = wt_val[20:8];
    wt_rem  = wt_val[7:0];
    wt_inc  = (wt_rem > 8'd128) || ((wt_rem == 8'd128) && wt_quo[0]);
    wt_rnd  = wt_quo + {12'd0, wt_inc};
    if (wt_val <= 21'sd0) begin
      wt_out = 8'd0;
    end else if (wt_rnd > 13'd255) begin
      wt_out = 8'd255;
    end else begin
      wt_out = wt_rnd[7:0];
    end
  end

  always_comb begin
    case (cfg_i.method) inside
      fa_pkg::FA_M_AVERAGE:                        res_o = avg_out;
      fa_pkg::FA_M_SQUARE, fa_pkg::FA_M_PRODUCT:   res_o = sq_out;
      fa_pkg::FA_M_WEIGHTED:                       res_o = wt_out;
      default:                                     res_o = avg_out;
    endcase
  end

endmodule

// File: rtl/frame_accumulator_unit.sv
// top level: running per-pixel rgb accumulator over a frame store
`timescale 1ns / 1ps
// an input word is held in stage one, then its result word in the output queue
// throughput: one word per cycle when ready is high; read, combine and write back
//   overlap, a write-to-read bypass covers the same entry in adjacent words
// reset: control clears at once, then a clearing pass over all MAX_PIXELS entries
//   zeroes the frame store with input ready low; config writes are taken throughout
module frame_accumulator_unit #(
  parameter int unsigned MAX_PIXELS = fa_pkg::FA_MAX_PIXELS
) (
  input  logic clk_i,
  input  logic rst_ni,
  fa_chan_if.sink   pix_in_i,
  fa_chan_if.source pix_out_o,
  fa_chan_if.sink   cfg_i
);

  localparam int unsigned AW         = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned MEM_W      = 3 * fa_pkg::FA_CH_W;
  localparam int unsigned FIFO_DEPTH = 3;
  localparam int unsigned RST_FRAME  =
    (fa_pkg::FA_FRAME_RST < MAX_PIXELS) ? fa_pkg::FA_FRAME_RST : MAX_PIXELS;
  localparam logic [AW-1:0] RST_LAST  = AW'(RST_FRAME - 1);
  localparam logic [AW-1:0] CLR_LAST  = AW'(MAX_PIXELS - 1);
  localparam logic [1:0]    PTR_LAST  = 2'(FIFO_DEPTH - 1);
  localparam logic [2:0]    FIFO_FULL = 3'(FIFO_DEPTH);

  // configuration
  fa_pkg::fa_method_e             method_q;
  logic [fa_pkg::FA_WEIGHT_W-1:0] weight_q;
  logic [AW-1:0]                  last_pos_q;
  logic [31:0]                    cfg_frame;
  logic [31:0]                    cfg_frame_m1;
  logic                           cfg_acc;
  fa_pkg::fa_lane_cfg_t           lane_cfg;

  // clearing pass
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  // position and stage one
  logic [AW-1:0]          pos_q;
  logic                   in_acc;
  logic                   s1_valid_q;
  fa_pkg::fa_pix_in_t     s1_pix_q;
  logic [AW-1:0]          s1_addr_q;
  logic                   s1_last_q;
  logic                   fwd_hit_q;
  logic [MEM_W-1:0]       fwd_data_q;
  logic [MEM_W-1:0]       rdata;
  logic [MEM_W-1:0]       acc_word;
  logic [MEM_W-1:0]       res_word;
  logic [fa_pkg::FA_CH_W-1:0] res0, res1, res2;

  // ram write port
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [MEM_W-1:0] ram_wdata;

  // output queue
  fa_pkg::fa_pix_out_t fifo_q [FIFO_DEPTH];
  logic [1:0]          wr_ptr_q;
  logic [1:0]          rd_ptr_q;
  logic [1:0]          cnt_q;
  logic                push;
  logic                pop;
  logic [2:0]          occ;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign cfg_frame    = 32'(cfg_i.data.wdata);
  assign cfg_frame_m1 = cfg_frame - 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q   <= fa_pkg::FA_M_AVERAGE;
      weight_q   <= fa_pkg::FA_WEIGHT_W'(fa_pkg::FA_WEIGHT_RST);
      last_pos_q <= RST_LAST;
    end else if (cfg_acc) begin
      unique case (cfg_i.data.reg_idx)
        fa_pkg::FA_CFG_METHOD: begin
          method_q <= fa_pkg::fa_method_e'(cfg_i.data.wdata[1:0]);
        end
        fa_pkg::FA_CFG_WEIGHT: begin
          if (cfg_i.data.wdata[fa_pkg::FA_WEIGHT_W-1:0] >
              fa_pkg::FA_WEIGHT_W'(fa_pkg::FA_WEIGHT_MAX)) begin
            weight_q <= fa_pkg::FA_WEIGHT_W'(fa_pkg::FA_WEIGHT_MAX);
          end else begin
            weight_q <= cfg_i.data.wdata[fa_pkg::FA_WEIGHT_W-1:0];
          end
        end
        fa_pkg::FA_CFG_FRAME: begin
          // zero means one pixel, oversize means the whole store
          if (cfg_frame == 32'd0) begin
            last_pos_q <= '0;
          end else if (cfg_frame > 32'(MAX_PIXELS)) begin
            last_pos_q <= CLR_LAST;
          end else begin
            last_pos_q <= cfg_frame_m1[AW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign lane_cfg.method = method_q;
  assign lane_cfg.weight = weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == CLR_LAST) begin
        clr_q <= 1'b0;
      end
    end
  end

  assign occ             = {2'b00, s1_valid_q} + {1'b0, cnt_q};
  assign pix_in_i.ready  = !clr_q && (occ < FIFO_FULL);
  assign in_acc          = pix_in_i.valid && pix_in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      if (in_acc) begin
        pos_q <= (pos_q >= last_pos_q) ? '0 : pos_q + AW'(1);
      end
    end
  end

  // payload of stage one, plus bypass when the word ahead writes the entry we read
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q   <= pix_in_i.data;
      s1_addr_q  <= pos_q;
      s1_last_q  <= (pos_q >= last_pos_q);
      fwd_hit_q  <= s1_valid_q && (s1_addr_q == pos_q);
      fwd_data_q <= res_word;
    end
  end

  assign acc_word = fwd_hit_q ? fwd_data_q : rdata;

  fa_lane u_lane0 (
    .cfg_i (lane_cfg),
    .acc_i (acc_word[3*fa_pkg::FA_CH_W-1:2*fa_pkg::FA_CH_W]),
    .pix_i (s1_pix_q.in_ch0),
    .res_o (res0)
  );

  fa_lane u_lane1 (
    .cfg_i (lane_cfg),
    .acc_i (acc_word[2*fa_pkg::FA_CH_W-1:fa_pkg::FA_CH_W]),
    .pix_i (s1_pix_q.in_ch1),
    .res_o (res1)
  );

  fa_lane u_lane2 (
    .cfg_i (lane_cfg),
    .acc_i (acc_word[fa_pkg::FA_CH_W-1:0]),
    .pix_i (s1_pix_q.in_ch2),
    .res_o (res2)
  );

  assign res_word  = {res0, res1, res2};
  assign ram_we    = clr_q || s1_valid_q;
  assign ram_waddr = clr_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clr_q ? '0 : res_word;

  fa_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (pos_q),
    .rdata_o (rdata)
  );

  // result queue decouples the store pipeline from output stalls
  assign push = s1_valid_q;
  assign pop  = pix_out_o.valid && pix_out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 2'd1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 2'd1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q].out_ch0    <= res0;
      fifo_q[wr_ptr_q].out_ch1    <= res1;
      fifo_q[wr_ptr_q].out_ch2    <= res2;
      fifo_q[wr_ptr_q].frame_last <= s1_last_q;
    end
  end

  assign pix_out_o.valid = (cnt_q != 2'd0);
  assign pix_out_o.data  = fifo_q[rd_ptr_q];

endmodule

// File: tb/tb_frame_accumulator_unit.sv
// testbench for frame_accumulator_unit: self-predicting per-pixel accumulator check
`timescale 1ns / 1ps
module tb_frame_accumulator_unit;
  import fa_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [FA_CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;

  fa_chan_if #(.payload_t(fa_pix_in_t))  pix_in_if ();
  fa_chan_if #(.payload_t(fa_pix_out_t)) pix_out_if ();
  fa_chan_if #(.payload_t(fa_cfg_t))     cfg_if ();

  frame_accumulator_unit DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_in_i  (pix_in_if),
    .pix_out_o (pix_out_if),
    .cfg_i     (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the block state
  fa_method_e              method_cfg = FA_M_AVERAGE;
  logic [FA_WEIGHT_W-1:0]  weight_cfg = FA_WEIGHT_W'(FA_WEIGHT_RST);
  logic [FA_FRAME_W-1:0]   frame_cfg  = FA_FRAME_W'(FA_FRAME_RST);
  int unsigned             pixel_pos_model = 0;
  bit [FA_CH_W-1:0]        store_model [FA_MAX_PIXELS][3];

  fa_pix_out_t acc_results_q [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;

  function automatic logic [7:0] blend_channel(logic [7:0] acc, logic [7:0] px);
    int s, v, q, r, w;
    case (method_cfg)
      FA_M_AVERAGE: begin
        s = int'(acc) + int'(px);
        q = (s >> 1) + ((s & 1) & ((s >> 1) & 1));
      end
      FA_M_SQUARE, FA_M_PRODUCT: begin
        q = int'(acc) + int'(px) * int'(px);
      end
      default: begin
        w = (weight_cfg > FA_WEIGHT_MAX) ? FA_WEIGHT_MAX : int'(weight_cfg);
        v = int'(acc) * 256 + w * (int'(px) - int'(acc));
        if (v <= 0) begin
          q = 0;
        end else begin
          q = v >>> 8;
          r = v & 255;
          // round half to even
          if (r > 128 || (r == 128 && (q % 2) == 1)) q = q + 1;
        end
      end
    endcase
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic fa_pix_out_t accumulate_pixel(fa_pix_in_t px);
    fa_pix_out_t res;
    int unsigned span;
    logic [7:0] ins [3];
    logic [7:0] outs [3];
    span = (frame_cfg == 0) ? 1 :
           ((frame_cfg > FA_MAX_PIXELS) ? FA_MAX_PIXELS : int'(frame_cfg));
    ins = '{px.in_ch0, px.in_ch1, px.in_ch2};
    for (int c = 0; c < 3; c++) begin
      outs[c] = blend_channel(store_model[pixel_pos_model][c], ins[c]);
      store_model[pixel_pos_model][c] = outs[c];
    end
    res.out_ch0    = outs[0];
    res.out_ch1    = outs[1];
    res.out_ch2    = outs[2];
    res.frame_last = (pixel_pos_model >= span - 1);
    pixel_pos_model = res.frame_last ? 0 : pixel_pos_model + 1;
    return res;
  endfunction

  function automatic fa_pix_in_t rgb(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    fa_pix_in_t px;
    px.in_ch0 = a;
    px.in_ch1 = b;
    px.in_ch2 = c;
    return px;
  endfunction

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(3));
      3: return 8'($urandom_range(255, 252));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // leaves valid high so back-to-back words need no second assignment
  task automatic send_pixel(input fa_pix_in_t px);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in_if.valid <= 1'b1;
    pix_in_if.data  <= px;
    do @(posedge clk_i); while (!pix_in_if.ready);
    acc_results_q.push_back(accumulate_pixel(px));
  endtask

  // stop offering pixels and let the pipeline empty
  task automatic settle();
    pix_in_if.valid <= 1'b0;
    while (acc_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [FA_CFG_IDX_W-1:0] idx,
                           input logic [FA_CFG_DATA_W-1:0] wdata);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{reg_idx: idx, wdata: wdata};
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      FA_CFG_METHOD: method_cfg = fa_method_e'(wdata[1:0]);
      FA_CFG_WEIGHT: weight_cfg = wdata[FA_WEIGHT_W-1:0];
      FA_CFG_FRAME:  frame_cfg  = wdata[FA_FRAME_W-1:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pix_out_if.ready <= 1'b0;
    end else begin
      pix_out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    fa_pix_out_t want;
    if (rst_ni && pix_out_if.valid && pix_out_if.ready) begin
      if (acc_results_q.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none, got %h",
                 $time, pix_out_if.data);
        mismatch_count++;
      end else begin
        want = acc_results_q.pop_front();
        check_field("out_ch0", 32'(want.out_ch0), 32'(pix_out_if.data.out_ch0));
        check_field("out_ch1", 32'(want.out_ch1), 32'(pix_out_if.data.out_ch1));
        check_field("out_ch2", 32'(want.out_ch2), 32'(pix_out_if.data.out_ch2));
        check_field("frame_last", 32'(want.frame_last),
                    32'(pix_out_if.data.frame_last));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** frame_accumulator_unit: FAILED **");
    $finish;
  end

  // defaults after reset; the first word waits out the store clearing pass
  task automatic test_reset_defaults();
    write_reg(CFG_IDX_UNUSED, '1);
    send_pixel(rgb(8'd0, 8'd0, 8'd0));
    send_pixel(rgb(8'd255, 8'd255, 8'd255));
    send_pixel(rgb(8'h55, 8'hAA, 8'h01));
  endtask

  task automatic test_methods();
    logic [FA_CFG_DATA_W-1:0] wd;
    // shrinking to two pixels makes the next word close the frame and wrap the position
    write_reg(FA_CFG_FRAME, 17'd2);
    wd = '1;
    wd[1:0] = FA_M_SQUARE;
    write_reg(FA_CFG_METHOD, wd);
    send_pixel(rgb(8'd255, 8'd1, 8'd0));
    send_pixel(rgb(8'd15, 8'd16, 8'd2));
    write_reg(FA_CFG_METHOD, FA_CFG_DATA_W'(FA_M_PRODUCT));
    send_pixel(rgb(8'd0, 8'd255, 8'd11));
    send_pixel(rgb(8'd1, 8'd2, 8'd3));
    // weighted with the reset weight of one half
    write_reg(FA_CFG_METHOD, FA_CFG_DATA_W'(FA_M_WEIGHTED));
    send_pixel(rgb(8'd255, 8'd0, 8'd128));
    send_pixel(rgb(8'd1, 8'd3, 8'd254));
    write_reg(FA_CFG_WEIGHT, 17'd0);
    send_pixel(rgb(8'd200, 8'd100, 8'd50));
    write_reg(FA_CFG_WEIGHT, FA_CFG_DATA_W'(FA_WEIGHT_MAX));
    send_pixel(rgb(8'd255, 8'd0, 8'd7));
    // weight beyond two is clamped
    write_reg(FA_CFG_WEIGHT, 17'h1FFFF);
    send_pixel(rgb(8'd255, 8'd0, 8'd1));
    send_pixel(rgb(8'd0, 8'd255, 8'd128));
    write_reg(FA_CFG_WEIGHT, 17'd1);
    send_pixel(rgb(8'd3, 8'd250, 8'd129));
    write_reg(CFG_IDX_UNUSED, 17'h0AAAA);
    send_pixel(rgb(8'd9, 8'd9, 8'd9));
    write_reg(FA_CFG_METHOD, FA_CFG_DATA_W'(FA_M_AVERAGE));
    send_pixel(rgb(8'd255, 8'd255, 8'd255));
    send_pixel(rgb(8'd0, 8'd1, 8'd3));
  endtask

  task automatic test_frame_sizes();
    // size zero acts as one: every pixel closes a frame
    write_reg(FA_CFG_FRAME, 17'd0);
    send_pixel(rgb(8'd10, 8'd20, 8'd30));
    send_pixel(rgb(8'd40, 8'd50, 8'd60));
    write_reg(FA_CFG_FRAME, 17'd8);
    repeat (6) send_pixel(rgb(rand_channel(), rand_channel(), rand_channel()));
    // shrink below the current position mid-frame
    write_reg(FA_CFG_FRAME, 17'd3);
    repeat (3) send_pixel(rgb(rand_channel(), rand_channel(), rand_channel()));
    write_reg(FA_CFG_FRAME, 17'd1);
    send_pixel(rgb(8'd128, 8'd127, 8'd64));
  endtask

  task automatic test_backpressure();
    settle();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    write_reg(FA_CFG_FRAME, 17'd5);
    write_reg(FA_CFG_METHOD, FA_CFG_DATA_W'(FA_M_WEIGHTED));
    hold_request = 300;
    repeat (64) send_pixel(rgb(rand_channel(), rand_channel(), rand_channel()));
    settle();
  endtask

  task automatic test_random_phase(input int unsigned src_pct, input int unsigned snk_pct,
                                   input int unsigned n_items);
    int unsigned left, seg;
    logic [FA_CFG_DATA_W-1:0] wd;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    left = n_items;
    while (left > 0) begin
      seg = $urandom_range(80, 20);
      if (seg > left) seg = left;
      if ($urandom_range(1)) begin
        wd = 17'($urandom);
        wd[1:0] = 2'($urandom_range(3));
        write_reg(FA_CFG_METHOD, wd);
      end
      if ($urandom_range(1)) begin
        wd = 17'($urandom);
        case ($urandom_range(7))
          0: wd[9:0] = 10'd0;
          1: wd[9:0] = 10'(FA_WEIGHT_MAX);
          2: wd[9:0] = 10'($urandom_range(1023, 513));
          default: wd[9:0] = 10'($urandom_range(512));
        endcase
        write_reg(FA_CFG_WEIGHT, wd);
      end
      if ($urandom_range(1)) begin
        case ($urandom_range(9))
          0: wd = 17'd0;
          1: wd = 17'h1FFFF;
          2: wd = 17'($urandom_range(131071, 65537));
          3: wd = 17'($urandom_range(3000, 17));
          default: wd = 17'($urandom_range(16, 1));
        endcase
        write_reg(FA_CFG_FRAME, wd);
      end
      if ($urandom_range(7) == 0) write_reg(CFG_IDX_UNUSED, 17'($urandom));
      repeat (seg) send_pixel(rgb(rand_channel(), rand_channel(), rand_channel()));
      left -= seg;
    end
  endtask

  // oversized frame value clamps to the whole store, so no word closes a frame
  task automatic test_full_frame();
    settle();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    write_reg(FA_CFG_FRAME, 17'd1);
    send_pixel(rgb(8'd1, 8'd2, 8'd3));
    write_reg(FA_CFG_FRAME, 17'h1FFFF);
    write_reg(FA_CFG_METHOD, FA_CFG_DATA_W'(FA_M_AVERAGE));
    repeat (64) send_pixel(rgb(rand_channel(), rand_channel(), rand_channel()));
    settle();
  endtask

  initial begin
    rst_ni <= 1'b0;
    pix_in_if.valid  <= 1'b0;
    pix_in_if.data   <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.data      <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_methods();
    test_frame_sizes();
    test_backpressure();
    test_random_phase(0, 0, 300);
    test_random_phase(73, 0, 300);
    test_random_phase(0, 73, 300);
    test_random_phase(24, 24, 300);
    test_full_frame();
    settle();

    if (mismatch_count == 0 && acc_results_q.size() == 0) begin
      $display("** frame_accumulator_unit: PASSED **");
    end else begin
      $display("** frame_accumulator_unit: FAILED **");
    end
    $finish;
  end

endmodule
